>>> rtl/sracp_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the register access command parser: request codes,
// context phase codes, register map constants and status structs. No dependencies.
package sracp_pkg;

	// Default framing sizes, in bytes
	localparam int ADDR_BYTES_DEF = 4;
	localparam int LEN_BYTES_DEF  = 2;
	localparam int REG_BYTES_DEF  = 4;

	// Request operation codes
	localparam logic [1:0] OP_RX  = 2'd0;
	localparam logic [1:0] OP_TX  = 2'd1;
	localparam logic [1:0] OP_EOT = 2'd2;

	// Context select
	localparam logic CMD_RD = 1'b0;
	localparam logic CMD_WR = 1'b1;

	// Context phase codes
	localparam logic [2:0] PH_INITIAL   = 3'd0;
	localparam logic [2:0] PH_ADDRESS   = 3'd1;
	localparam logic [2:0] PH_LENGTH    = 3'd2;
	localparam logic [2:0] PH_SENDING   = 3'd3;
	localparam logic [2:0] PH_VALUE     = 3'd4;
	localparam logic [2:0] PH_ERROR     = 3'd5;
	localparam logic [2:0] PH_COMPLETED = 3'd6;

	// Register map: readable window and the single writable address
	localparam int          MAP_FIRST = 1;
	localparam int          MAP_LAST  = 10;
	localparam int          WR_ADDR   = 1;
	localparam logic [27:0] MAP_LOW   = 28'hABBCCDD;

	// Step handed to one context
	typedef struct packed {
		logic       act;
		logic [1:0] op;
		logic [7:0] rx_byte;
	} ctx_step_t;

	// Read context status after the step
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       error;
		logic       sending;
	} rd_stat_t;

	// Register word: address low nibble on top of the fixed pattern
	function automatic logic [31:0] map_word(input logic [3:0] addr_lo);
		map_word = {addr_lo, MAP_LOW};
	endfunction

endpackage

>>> rtl/sracp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for parser requests and responses.
// Standalone; field widths are fixed by the request and response formats.
interface sracp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output command, output rx_byte,
		input ready);
	modport sink (input valid, input operation, input command, input rx_byte,
		output ready);
endinterface

interface sracp_rsp_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       in_error;
	logic       sending;

	modport source (output valid, output tx_valid, output tx_byte, output in_error,
		output sending, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input in_error,
		input sending, output ready);
endinterface

>>> rtl/spi_register_access_command_parser.sv
`timescale 1ns / 1ps
// Register access command parser, slave side.
// Request channel (req): one byte event per request - a received byte, a
// transmit byte request or an end of transaction - tagged with the read or
// write context it belongs to. Response channel (rsp): exactly one response
// per request, carrying the byte to send (tx_valid/tx_byte), the error flag
// of the selected context and the read context's sending flag.
// An accepted request is held in the input register; its context update is
// then captured into the response register and presented on rsp.
// Throughput: one request per clock while rsp does not stall; the context
// update between the input register and the response register is combinational.
// When rsp stalls, the response register holds and the input register still
// takes one more request; req.ready drops once both are full.
// Reset (arst_n low) returns both contexts to their initial phase with all
// address and count fields cleared and empties the pipeline.
// Depends on sracp_pkg, sracp_if, sracp_rd_ctx and sracp_wr_ctx.
module spi_register_access_command_parser
	import sracp_pkg::*;
#(
	parameter int ADDR_BYTES = ADDR_BYTES_DEF,
	parameter int LEN_BYTES  = LEN_BYTES_DEF,
	parameter int REG_BYTES  = REG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sracp_req_if.sink  req,
	sracp_rsp_if.source rsp
);

	logic       valid_s1;
	logic [1:0] op_s1;
	logic       cmd_s1;
	logic [7:0] rx_s1;
	logic       advance;
	logic       accept;
	ctx_step_t  rd_step;
	ctx_step_t  wr_step;
	rd_stat_t   rd_stat;
	logic       wr_error;
	logic       out_valid_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic       in_error_q;
	logic       sending_q;

	// Handshake: stage 1 moves on when the response register is free
	assign advance    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready  = !valid_s1 || advance;
	assign accept     = req.valid && req.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.operation;
			cmd_s1 <= req.command;
			rx_s1  <= req.rx_byte;
		end
	end

	// Route the request to its context
	assign rd_step.act     = advance && (cmd_s1 == CMD_RD);
	assign rd_step.op      = op_s1;
	assign rd_step.rx_byte = rx_s1;
	assign wr_step.act     = advance && (cmd_s1 == CMD_WR);
	assign wr_step.op      = op_s1;
	assign wr_step.rx_byte = rx_s1;

	sracp_rd_ctx #(
		.ADDR_BYTES(ADDR_BYTES),
		.LEN_BYTES (LEN_BYTES),
		.REG_BYTES (REG_BYTES)
	) u_rd_ctx (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (rd_step),
		.stat  (rd_stat)
	);

	sracp_wr_ctx #(
		.ADDR_BYTES(ADDR_BYTES),
		.REG_BYTES (REG_BYTES)
	) u_wr_ctx (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (wr_step),
		.error (wr_error)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_valid_q <= rd_stat.tx_valid;
			tx_byte_q  <= rd_stat.tx_byte;
			in_error_q <= (cmd_s1 == CMD_RD) ? rd_stat.error : wr_error;
			sending_q  <= rd_stat.sending;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.tx_valid = tx_valid_q;
	assign rsp.tx_byte  = tx_byte_q;
	assign rsp.in_error = in_error_q;
	assign rsp.sending  = sending_q;

`ifndef SYNTH
	// A sent byte leaves the read context still sending
	a_tx_while_sending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tx_valid |-> rsp.sending)
		else $error("byte sent outside the sending phase");

	// Never a byte and an error in the same response
	a_tx_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tx_valid |-> !rsp.in_error)
		else $error("byte sent while in error");

	// No byte means a zero byte field
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.tx_valid |-> rsp.tx_byte == 8'd0)
		else $error("nonzero byte without tx_valid");

	// A stalled request in stage 1 stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(cmd_s1)
			&& $stable(rx_s1))
		else $error("stage 1 request lost during stall");
`endif

endmodule

>>> rtl/sracp_rd_ctx.sv
`timescale 1ns / 1ps
// Read command context: address and length collection, then register bytes out.
// Depends on sracp_pkg.
module sracp_rd_ctx
	import sracp_pkg::*;
#(
	parameter int ADDR_BYTES = ADDR_BYTES_DEF,
	parameter int LEN_BYTES  = LEN_BYTES_DEF,
	parameter int REG_BYTES  = REG_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctx_step_t step,
	output rd_stat_t  stat
);

	localparam int AW  = 8 * ADDR_BYTES;
	localparam int RW  = 8 * REG_BYTES;
	localparam int ACW = $clog2(ADDR_BYTES + 1);
	localparam int LCW = $clog2(LEN_BYTES + 1);
	localparam int BCW = $clog2(REG_BYTES + 1);

	logic [2:0]     phase_q, phase_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic [ACW-1:0] acnt_q, acnt_d;
	logic [LCW-1:0] lcnt_q, lcnt_d;
	logic [RW-1:0]  shift_q, shift_d;
	logic [BCW-1:0] left_q, left_d;
	logic           tx_valid;
	logic [7:0]     tx_byte;
	logic [31:0]    word;
	logic           addr_ok;

	// Register map lookup at the current address
	assign word    = map_word(addr_q[3:0]);
	assign addr_ok = (addr_q >= AW'(MAP_FIRST)) && (addr_q <= AW'(MAP_LAST));

	// Next state for one step
	always_comb begin
		phase_d  = phase_q;
		addr_d   = addr_q;
		acnt_d   = acnt_q;
		lcnt_d   = lcnt_q;
		shift_d  = shift_q;
		left_d   = left_q;
		tx_valid = 1'b0;
		tx_byte  = 8'd0;
		if (step.act) begin
			unique case (step.op)
				OP_RX: begin
					// idle, done or sending: start a fresh command
					if (phase_d == PH_SENDING || phase_d == PH_INITIAL ||
							phase_d == PH_COMPLETED) begin
						addr_d  = '0;
						acnt_d  = '0;
						lcnt_d  = '0;
						shift_d = '0;
						left_d  = '0;
						phase_d = PH_ADDRESS;
					end
					if (phase_d == PH_ADDRESS) begin
						if (acnt_d < ACW'(ADDR_BYTES)) begin
							for (int i = 0; i < ADDR_BYTES; i++) begin
								if (acnt_d == ACW'(i))
									addr_d[8*i +: 8] = addr_d[8*i +: 8] | step.rx_byte;
							end
							acnt_d = acnt_d + ACW'(1);
							if (acnt_d == ACW'(ADDR_BYTES))
								phase_d = PH_LENGTH;
						end else begin
							phase_d = PH_ERROR;
						end
					end else if (phase_d == PH_LENGTH) begin
						if (lcnt_d < LCW'(LEN_BYTES)) begin
							lcnt_d = lcnt_d + LCW'(1);
							if (lcnt_d == LCW'(LEN_BYTES))
								phase_d = PH_SENDING;
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end
				OP_TX: begin
					if (phase_q == PH_SENDING) begin
						if (left_q == '0) begin
							// fetch the next register word
							if (addr_ok) begin
								addr_d   = addr_q + AW'(1);
								tx_valid = 1'b1;
								tx_byte  = word[7:0];
								shift_d  = word[RW-1:0] >> 8;
								left_d   = BCW'(REG_BYTES - 1);
							end else begin
								phase_d = PH_ERROR;
							end
						end else begin
							tx_valid = 1'b1;
							tx_byte  = shift_q[7:0];
							shift_d  = shift_q >> 8;
							left_d   = left_q - BCW'(1);
						end
					end
				end
				OP_EOT: begin
					addr_d  = '0;
					acnt_d  = '0;
					lcnt_d  = '0;
					shift_d = '0;
					left_d  = '0;
					phase_d = PH_COMPLETED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INITIAL;
			addr_q  <= '0;
			acnt_q  <= '0;
			lcnt_q  <= '0;
			shift_q <= '0;
			left_q  <= '0;
		end else begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			acnt_q  <= acnt_d;
			lcnt_q  <= lcnt_d;
			shift_q <= shift_d;
			left_q  <= left_d;
		end
	end

	assign stat.tx_valid = tx_valid;
	assign stat.tx_byte  = tx_byte;
	assign stat.error    = (phase_d == PH_ERROR);
	assign stat.sending  = (phase_d == PH_SENDING);

endmodule

>>> rtl/sracp_wr_ctx.sv
`timescale 1ns / 1ps
// Write command context: address collection, then register values checked
// against the writable address. Depends on sracp_pkg.
module sracp_wr_ctx
	import sracp_pkg::*;
#(
	parameter int ADDR_BYTES = ADDR_BYTES_DEF,
	parameter int REG_BYTES  = REG_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctx_step_t step,
	output logic      error
);

	localparam int AW  = 8 * ADDR_BYTES;
	localparam int ACW = $clog2(ADDR_BYTES + 1);
	localparam int VCW = $clog2(REG_BYTES + 1);

	logic [2:0]     phase_q, phase_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic [ACW-1:0] acnt_q, acnt_d;
	logic [VCW-1:0] vcnt_q, vcnt_d;

	// Next state for one step; value bytes are only counted, the map ignores them
	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		acnt_d  = acnt_q;
		vcnt_d  = vcnt_q;
		if (step.act) begin
			unique case (step.op)
				OP_RX: begin
					if (phase_d == PH_INITIAL || phase_d == PH_COMPLETED) begin
						addr_d  = '0;
						acnt_d  = '0;
						vcnt_d  = '0;
						phase_d = PH_ADDRESS;
					end
					if (phase_d == PH_ADDRESS) begin
						if (acnt_d < ACW'(ADDR_BYTES)) begin
							for (int i = 0; i < ADDR_BYTES; i++) begin
								if (acnt_d == ACW'(i))
									addr_d[8*i +: 8] = addr_d[8*i +: 8] | step.rx_byte;
							end
							acnt_d = acnt_d + ACW'(1);
							if (acnt_d == ACW'(ADDR_BYTES))
								phase_d = PH_VALUE;
						end else begin
							phase_d = PH_ERROR;
						end
					end else if (phase_d == PH_VALUE) begin
						if (vcnt_d < VCW'(REG_BYTES)) begin
							vcnt_d = vcnt_d + VCW'(1);
							// full value: the current address must be the writable one, then it steps on
							if (vcnt_d == VCW'(REG_BYTES)) begin
								vcnt_d = '0;
								if (addr_d != AW'(WR_ADDR))
									phase_d = PH_ERROR;
								else
									addr_d = addr_d + AW'(1);
							end
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end
				OP_EOT: begin
					addr_d  = '0;
					acnt_d  = '0;
					vcnt_d  = '0;
					phase_d = PH_COMPLETED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INITIAL;
			addr_q  <= '0;
			acnt_q  <= '0;
			vcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			acnt_q  <= acnt_d;
			vcnt_q  <= vcnt_d;
		end
	end

	assign error = (phase_d == PH_ERROR);

endmodule

>>> bench/spi_register_access_command_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for spi_register_access_command_parser: directed and random
// read/write command traffic, with a response scoreboard. Depends on sracp_pkg,
// sracp_if and the parser RTL.
module spi_register_access_command_parser_tb;
	import sracp_pkg::*;

	localparam int ADDR_N      = ADDR_BYTES_DEF;
	localparam int LEN_N       = LEN_BYTES_DEF;
	localparam int REG_N       = REG_BYTES_DEF;
	localparam logic [1:0] OP_NONE = 2'd3;	// unused code, must leave state alone
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN       = 6;
	localparam int CYCLE_LIMIT = 200000;

	// One response as seen on rsp
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       in_error;
		logic       sending;
	} reply_t;

	// Tracks both command contexts and the responses they must produce
	class cmd_scoreboard;
		reply_t     expected_replies[$];
		int         fail_count;
		logic [2:0] rd_phase, wr_phase;
		logic [31:0] rd_addr, rd_shift, wr_addr, wr_value;
		logic [2:0] rd_addr_cnt, rd_len_cnt, rd_left, wr_addr_cnt, wr_val_cnt;

		function new();
			fail_count = 0;
			clear_read();
			clear_write();
			rd_phase = PH_INITIAL;
			wr_phase = PH_INITIAL;
		endfunction

		function void clear_read();
			rd_addr     = '0;
			rd_addr_cnt = '0;
			rd_len_cnt  = '0;
			rd_shift    = '0;
			rd_left     = '0;
		endfunction

		function void clear_write();
			wr_addr     = '0;
			wr_addr_cnt = '0;
			wr_value    = '0;
			wr_val_cnt  = '0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Advance the context model by one accepted request, queue its response
		function void note_request(logic [1:0] op, logic c, logic [7:0] b);
			reply_t r;
			r = '0;
			case (op)
				OP_RX: begin
					if (c == CMD_RD) begin
						// new command starts from idle, completed or mid-send
						if (rd_phase inside {PH_SENDING, PH_INITIAL, PH_COMPLETED}) begin
							clear_read();
							rd_phase = PH_ADDRESS;
						end
						if (rd_phase == PH_ADDRESS) begin
							if (rd_addr_cnt < ADDR_N) begin
								rd_addr = rd_addr | (32'(b) << (8 * rd_addr_cnt));
								rd_addr_cnt++;
								if (rd_addr_cnt == ADDR_N)
									rd_phase = PH_LENGTH;
							end else
								rd_phase = PH_ERROR;
						end else if (rd_phase == PH_LENGTH) begin
							if (rd_len_cnt < LEN_N) begin
								rd_len_cnt++;
								if (rd_len_cnt == LEN_N)
									rd_phase = PH_SENDING;
							end else
								rd_phase = PH_ERROR;
						end
					end else begin
						if (wr_phase inside {PH_INITIAL, PH_COMPLETED}) begin
							clear_write();
							wr_phase = PH_ADDRESS;
						end
						if (wr_phase == PH_ADDRESS) begin
							if (wr_addr_cnt < ADDR_N) begin
								wr_addr = wr_addr | (32'(b) << (8 * wr_addr_cnt));
								wr_addr_cnt++;
								if (wr_addr_cnt == ADDR_N)
									wr_phase = PH_VALUE;
							end else
								wr_phase = PH_ERROR;
						end else if (wr_phase == PH_VALUE) begin
							if (wr_val_cnt < REG_N) begin
								wr_value[8 * wr_val_cnt +: 8] = b;
								wr_val_cnt++;
								// full word: only the one writable address passes
								if (wr_val_cnt == REG_N) begin
									wr_val_cnt = '0;
									if (wr_addr != WR_ADDR)
										wr_phase = PH_ERROR;
									else
										wr_addr++;
								end
							end else
								wr_phase = PH_ERROR;
						end
					end
				end
				OP_TX: begin
					// only the read context answers, and only while sending
					if (c == CMD_RD && rd_phase == PH_SENDING) begin
						if (rd_left == 0) begin
							if (rd_addr >= MAP_FIRST && rd_addr <= MAP_LAST) begin
								rd_shift = {rd_addr[3:0], MAP_LOW};
								rd_addr++;
								rd_left = REG_N;
							end else
								rd_phase = PH_ERROR;
						end
						if (rd_phase == PH_SENDING) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = rd_shift[7:0];
							rd_shift   = rd_shift >> 8;
							rd_left--;
						end
					end
				end
				OP_EOT: begin
					if (c == CMD_RD) begin
						clear_read();
						rd_phase = PH_COMPLETED;
					end else begin
						clear_write();
						wr_phase = PH_COMPLETED;
					end
				end
				default: ;
			endcase
			r.in_error = ((c == CMD_RD) ? rd_phase : wr_phase) == PH_ERROR;
			r.sending  = rd_phase == PH_SENDING;
			expected_replies.push_back(r);
		endfunction

		// Compare one accepted response against the oldest expectation
		function void check_response(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$error("response with no request pending: %p", got);
				fail_count++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.tx_valid !== want.tx_valid) begin
				$error("tx_valid: expected %0d, got %0d", want.tx_valid, got.tx_valid);
				fail_count++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, got.tx_byte);
				fail_count++;
			end
			if (got.in_error !== want.in_error) begin
				$error("in_error: expected %0d, got %0d", want.in_error, got.in_error);
				fail_count++;
			end
			if (got.sending !== want.sending) begin
				$error("sending: expected %0d, got %0d", want.sending, got.sending);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   sent_count;
	int   cycle_count;
	int   hold_left;
	bit   hold_off_pending;
	bit   strays_on;
	cmd_scoreboard sb;

	sracp_req_if req_ch ();
	sracp_rsp_if rsp_ch ();

	spi_register_access_command_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Request and response monitors; responses are matched to requests in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.operation, req_ch.command, req_ch.rx_byte);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response({rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.in_error,
					rsp_ch.sending});
		end
	end

	// Response side: random stalls, plus one long hold-off on request
	initial begin
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request, with random idle cycles ahead of it, and wait for accept
	task automatic send_request(input logic [1:0] op, input logic c, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.command   <= c;
		req_ch.rx_byte   <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Any request at all, op code 3 included
	task automatic send_noise();
		send_request(2'($urandom_range(3)), 1'($urandom), 8'($urandom));
	endtask

	// Read command: address, length, transmit requests, optional end
	task automatic run_read_cmd(input logic [31:0] addr, input int reads, input bit close);
		for (int i = 0; i < ADDR_N + LEN_N + reads; i++) begin
			if (strays_on && $urandom_range(24) == 0)
				send_noise();
			if (i < ADDR_N)
				send_request(OP_RX, CMD_RD, addr[8 * i +: 8]);
			else if (i < ADDR_N + LEN_N)
				send_request(OP_RX, CMD_RD, 8'($urandom));
			else
				send_request(OP_TX, CMD_RD, 8'($urandom));
		end
		if (close)
			send_request(OP_EOT, CMD_RD, 8'($urandom));
	endtask

	// Write command: address, then whole words, optional end
	task automatic run_write_cmd(input logic [31:0] addr, input int words, input bit close);
		for (int i = 0; i < ADDR_N + REG_N * words; i++) begin
			if (strays_on && $urandom_range(24) == 0)
				send_noise();
			if (i < ADDR_N)
				send_request(OP_RX, CMD_WR, addr[8 * i +: 8]);
			else
				send_request(OP_RX, CMD_WR, 8'($urandom));
		end
		if (close)
			send_request(OP_EOT, CMD_WR, 8'($urandom));
	endtask

	// Mostly well-formed commands with random content, some noise
	task automatic run_random(input int until_count);
		int          pick;
		logic [31:0] addr;
		while (sent_count < until_count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				addr = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(11));
				run_read_cmd(addr, $urandom_range(12), $urandom_range(99) < 85);
			end else if (pick < 80) begin
				case ($urandom_range(5))
					0:       addr = $urandom();
					1:       addr = 32'($urandom_range(3));
					default: addr = WR_ADDR;
				endcase
				run_write_cmd(addr, $urandom_range(3), $urandom_range(99) < 85);
			end else
				repeat ($urandom_range(1, 4)) send_noise();
		end
	endtask

	// Main sequence
	initial begin
		sb = new();
		sent_count       = 0;
		strays_on        = 1'b0;
		hold_off_pending = 1'b0;
		send_idle_pct    = 37;
		recv_idle_pct    = 51;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_RX;
		req_ch.command   <= CMD_RD;
		req_ch.rx_byte   <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no-send transmit requests, unused op, read past the map end
		// into error, ignored byte in error, bad write address
		send_request(OP_TX, CMD_RD, 8'hFF);
		send_request(OP_TX, CMD_WR, 8'h00);
		send_request(OP_NONE, CMD_RD, 8'hA5);
		send_request(OP_EOT, CMD_WR, 8'h00);
		run_read_cmd(32'd10, REG_N + 1, 1'b0);
		send_request(OP_RX, CMD_RD, 8'h5A);
		send_request(OP_EOT, CMD_RD, 8'h00);
		run_write_cmd(32'hFFFF_FFFF, 1, 1'b1);

		// Random: receiver-heavy idling, then sender-heavy, then none
		strays_on = 1'b1;
		run_random(520);
		send_idle_pct = 51;
		recv_idle_pct = 37;
		run_random(1020);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_pending = 1'b1;
		run_random(1520);
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
